>>> rtl/b64se_pkg.sv
// Package for the base64 stream encoder: group record, queue sizing and
// the sextet-to-character mapping. No dependencies.
`default_nettype none

package b64se_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [7:0] PadChar    = 8'h3D;
  localparam logic [5:0] SextetMask = 6'h3F;

  localparam logic [1:0] CharFirst  = 2'd0;
  localparam logic [1:0] CharSecond = 2'd1;
  localparam logic [1:0] CharThird  = 2'd2;
  localparam logic [1:0] CharFourth = 2'd3;

  typedef struct packed {
    logic [23:0] bits;
    logic [1:0]  total;
    logic        last;
  } group_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  function automatic logic [7:0] sextet_to_char(input logic [5:0] s);
    logic [5:0] m;
    logic [7:0] c;
    m = s & SextetMask;
    if (m < 6'd26) begin
      c = 8'h41 + {2'b00, m};
    end else if (m < 6'd52) begin
      c = 8'h61 + {2'b00, m - 6'd26};
    end else if (m < 6'd62) begin
      c = 8'h30 + {2'b00, m - 6'd52};
    end else if (m == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> rtl/b64se_front.sv
// Front end: accepts bytes, holds up to two, and forms left-aligned groups.
// Depends on b64se_pkg.
`default_nettype none

module b64se_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [7:0]        data_byte_i,
  input  wire logic              final_byte_i,
  input  wire logic              q_full_i,
  output logic                   push_o,
  output b64se_pkg::group_t      push_group_o
);
  import b64se_pkg::*;

  logic [15:0] pend_q, pend_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [1:0]  held;
  logic [1:0]  total;
  logic        accept;
  logic        close;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign held       = (cnt_q == 2'd3) ? 2'd2 : cnt_q;
  assign total      = held + 2'd1;
  assign close      = (total == 2'd3) || final_byte_i;
  assign push_o     = accept && close;

  always_comb begin
    push_group_o.total = total;
    push_group_o.last  = final_byte_i;
    unique case (held)
      2'd0:    push_group_o.bits = {data_byte_i, 16'h0000};
      2'd1:    push_group_o.bits = {pend_q[7:0], data_byte_i, 8'h00};
      default: push_group_o.bits = {pend_q, data_byte_i};
    endcase
  end

  always_comb begin
    pend_d = pend_q;
    cnt_d  = cnt_q;
    if (accept) begin
      if (close) begin
        pend_d = 16'h0000;
        cnt_d  = 2'd0;
      end else begin
        pend_d = {pend_q[7:0], data_byte_i};
        cnt_d  = total;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 16'h0000;
      cnt_q  <= 2'd0;
    end else begin
      pend_q <= pend_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/b64se_queue.sv
// Short group queue between the front and back ends.
// Depends on b64se_pkg.
`default_nettype none

module b64se_queue (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  input  wire b64se_pkg::group_t     push_group_i,
  input  wire logic                  pop_i,
  output b64se_pkg::group_t          head_o,
  output b64se_pkg::queue_status_t   status_o
);
  import b64se_pkg::*;

  group_t               mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_q, rd_q;
  logic [QueueCntW-1:0] cnt_q;
  logic                 do_push, do_pop;

  assign status_o.full  = (cnt_q == QueueCntW'(QueueDepth));
  assign status_o.empty = (cnt_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign head_o         = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_group_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_q + QueuePtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_q + QueuePtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QueueCntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QueueCntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/b64se_back.sv
// Back end: turns each queued group into four characters, one per cycle while
// not stalled, through a registered output stage. Depends on b64se_pkg.
`default_nettype none

module b64se_back (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire b64se_pkg::group_t     head_i,
  input  wire logic                  q_empty_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [7:0]                 code_char_o,
  output logic                       group_end_o,
  output logic                       message_end_o
);
  import b64se_pkg::*;

  logic [1:0] idx_q;
  logic       valid_q;
  logic [7:0] char_q, char_d;
  logic       gend_q, mend_q;
  logic       load, take;
  logic [5:0] sextet;

  assign load  = !valid_q || !out_stall_i;
  assign take  = load && !q_empty_i;
  assign pop_o = take && (idx_q == CharFourth);

  always_comb begin
    unique case (idx_q)
      CharFirst:  sextet = head_i.bits[23:18];
      CharSecond: sextet = head_i.bits[17:12];
      CharThird:  sextet = head_i.bits[11:6];
      default:    sextet = head_i.bits[5:0];
    endcase
    char_d = sextet_to_char(sextet);
    if (idx_q == CharThird && head_i.total < 2'd2) begin
      char_d = PadChar;
    end
    if (idx_q == CharFourth && head_i.total < 2'd3) begin
      char_d = PadChar;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      char_q <= char_d;
      gend_q <= (idx_q == CharFourth);
      mend_q <= (idx_q == CharFourth) && head_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= CharFirst;
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= !q_empty_i;
      if (!q_empty_i) begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  assign out_valid_o   = valid_q;
  assign code_char_o   = char_q;
  assign group_end_o   = gend_q;
  assign message_end_o = mend_q;

endmodule

`default_nettype wire

>>> rtl/base64_stream_encoder_unit.sv
// Top level of the base64 stream encoder: front end, group queue, back end.
// Depends on b64se_pkg, b64se_front, b64se_queue and b64se_back.
//
// Input channel: one raw byte per item (data_byte_i) with final_byte_i set
// on the last byte of a message; accepted when in_valid_i is high and
// in_stall_o is low. Output channel: one base64 character per item
// (code_char_o), group_end_o on the fourth character of every group and
// message_end_o on the last character of a message; taken when out_valid_o
// is high and out_stall_i is low.
// The front end takes one byte per cycle while the queue is not full. The
// group a third or final byte closes is queued that cycle; its characters
// pass through the back end's character register to the output, one per
// cycle while the receiver does not stall. That single register sets the
// rate: four characters per group. A two-entry group queue lets the front
// end keep accepting while the back end drains.
// Reset clears the held bytes, the queue and the output valid.
// When the receiver stalls, the output holds; once the queue is full,
// in_stall_o rises until a group has been drained.
`default_nettype none

module base64_stream_encoder_unit (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       final_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      code_char_o,
  output logic            group_end_o,
  output logic            message_end_o
);
  import b64se_pkg::*;

  group_t        push_group;
  group_t        head;
  queue_status_t q_status;
  logic          push;
  logic          pop;

  b64se_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .final_byte_i (final_byte_i),
    .q_full_i     (q_status.full),
    .push_o       (push),
    .push_group_o (push_group)
  );

  b64se_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_group_i (push_group),
    .pop_i        (pop),
    .head_o       (head),
    .status_o     (q_status)
  );

  b64se_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .q_empty_i     (q_status.empty),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .code_char_o   (code_char_o),
    .group_end_o   (group_end_o),
    .message_end_o (message_end_o)
  );

endmodule

`default_nettype wire

>>> dv/base64_stream_encoder_unit_tb.sv
// Testbench for base64_stream_encoder_unit: drives byte items, predicts the
// character items in a scoreboard class and checks every character that leaves.
// Depends on b64se_pkg and the encoder RTL.
module base64_stream_encoder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam time ClkPeriod = 8ns;
  localparam int unsigned RandomItems = 100;
  localparam int unsigned HoldCycles = 80;
  localparam logic [8*64-1:0] CharSet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct packed {
    logic [7:0] code;
    logic       grp_end;
    logic       msg_end;
  } enc_char_t;

  class char_scoreboard;
    enc_char_t   expected_chars[$];
    logic [15:0] held_bytes;
    logic [1:0]  held_count;
    int unsigned fails;

    function new();
      held_bytes = '0;
      held_count = '0;
      fails      = 0;
    endfunction

    function logic [7:0] sextet_char(input logic [5:0] s);
      int idx;
      idx = 63 - int'(s);
      return CharSet[8*idx +: 8];
    endfunction

    function void note_char(input enc_char_t ch);
      expected_chars = {expected_chars, ch};
    endfunction

    function void add_byte(input logic [7:0] b, input logic fin);
      logic [1:0]  held;
      logic [1:0]  total;
      logic [23:0] bits;
      enc_char_t   ch;
      held  = (held_count == 2'd3) ? 2'd2 : held_count;
      total = held + 2'd1;
      if (total < 2'd3 && !fin) begin
        held_bytes = {held_bytes[7:0], b};
        held_count = total;
        return;
      end
      case (held)
        2'd0: bits = {b, 16'h0000};
        2'd1: bits = {held_bytes[7:0], b, 8'h00};
        default: bits = {held_bytes, b};
      endcase
      ch = '{code: sextet_char(bits[23:18]), grp_end: 1'b0, msg_end: 1'b0};
      note_char(ch);
      ch.code = sextet_char(bits[17:12]);
      note_char(ch);
      ch.code = (total >= 2'd2) ? sextet_char(bits[11:6]) : b64se_pkg::PadChar;
      note_char(ch);
      ch.code    = (total == 2'd3) ? sextet_char(bits[5:0]) : b64se_pkg::PadChar;
      ch.grp_end = 1'b1;
      ch.msg_end = fin;
      note_char(ch);
      held_bytes = '0;
      held_count = '0;
    endfunction

    function void check_char(input logic [7:0] c, input logic g, input logic m);
      enc_char_t want;
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected item code_char=%h group_end=%b message_end=%b",
                 $time, c, g, m);
        fails++;
        return;
      end
      want = expected_chars.pop_front();
      if (want.code !== c) begin
        $display("%0t: code_char expected %h actual %h", $time, want.code, c);
        fails++;
      end
      if (want.grp_end !== g) begin
        $display("%0t: group_end expected %b actual %b", $time, want.grp_end, g);
        fails++;
      end
      if (want.msg_end !== m) begin
        $display("%0t: message_end expected %b actual %b", $time, want.msg_end, m);
        fails++;
      end
    endfunction

    function int unsigned outstanding();
      return expected_chars.size();
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic [7:0] data_byte_i = 8'h00;
  logic       final_byte_i = 1'b0;
  logic       out_stall_i = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [7:0] code_char_o;
  logic       group_end_o;
  logic       message_end_o;

  char_scoreboard sb;
  int unsigned    tx_idle_pct = 16;
  int unsigned    rx_idle_pct = 16;
  bit             hold_request = 1'b0;
  bit             hold_done = 1'b0;

  base64_stream_encoder_unit i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .final_byte_i (final_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .code_char_o  (code_char_o),
    .group_end_o  (group_end_o),
    .message_end_o(message_end_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  task automatic send_item(input logic [7:0] b, input logic fin);
    in_valid_i   <= 1'b1;
    data_byte_i  <= b;
    final_byte_i <= fin;
    do @(posedge clk_i); while (in_stall_o);
    sb.add_byte(b, fin);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic send_message(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      send_item(8'($urandom_range(255)), i == len - 1);
    end
  endtask

  initial begin : rx_side
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        sb.check_char(code_char_o, group_end_o, message_end_o);
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  initial begin : watchdog
    #2ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : tx_side
    int unsigned sent;
    int unsigned len;
    sb   = new();
    sent = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single, double and triple byte messages at the byte extremes
    send_item(8'h00, 1'b1);
    send_item(8'hFF, 1'b1);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b1);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b1);
    // alphabet ends and the two symbol characters
    send_item(8'h00, 1'b0);
    send_item(8'h10, 1'b0);
    send_item(8'h83, 1'b1);
    send_item(8'hFB, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'hBF, 1'b1);
    // full group followed by a one byte closing group
    send_item(8'h4D, 1'b0);
    send_item(8'h61, 1'b0);
    send_item(8'h6E, 1'b0);
    send_item(8'h01, 1'b1);

    while (sent < RandomItems) begin
      len = $urandom_range(1, 9);
      if (sent >= 30 && sent < 60) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else begin
        tx_idle_pct = 16;
        rx_idle_pct = 16;
      end
      if (!hold_done && sent >= 80) begin
        hold_done    = 1'b1;
        tx_idle_pct  = 0;
        hold_request = 1'b1;
        len          = 20;
      end
      send_message(len);
      sent += len;
    end
    in_valid_i <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
